// File: sv/tdh_pkg.sv
// ----------------------------------------------------------------------------
// tdh_pkg
// Shared codes and types for the trigger delay / holdoff sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tdh_pkg;

   // Request codes carried by req_type.
   localparam logic [1:0] REQ_TICK      = 2'd0;
   localparam logic [1:0] REQ_INITIATE  = 2'd1;
   localparam logic [1:0] REQ_ABORT     = 2'd2;
   localparam logic [1:0] REQ_IMMEDIATE = 2'd3;

   // Sequencer state codes.
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_INIT    = 3'd1;
   localparam logic [2:0] ST_ARMED   = 3'd2;
   localparam logic [2:0] ST_DELAYED = 3'd3;
   localparam logic [2:0] ST_HELDOFF = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_DELAY_TICKS     = 2'd0;
   localparam logic [1:0] CSR_HOLDOFF_TICKS   = 2'd1;
   localparam logic [1:0] CSR_CONTINUOUS_MODE = 2'd2;

   localparam int CSR_DATA_W = 32;

   // One result beat.
   typedef struct packed {
      logic       fired;
      logic [2:0] fsm_state;
      logic       logic_restart;
      logic       armed_event;
      logic       delayed_event;
      logic       heldoff_event;
   } result_type;

endpackage

`default_nettype wire

// File: sv/tdh_step.sv
// ----------------------------------------------------------------------------
// tdh_step
// Next-state and result logic for one request of the trigger sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tdh_step #(
   parameter int TIMER_WIDTH = 32
) (
   input  wire logic [1:0]             req_code,
   input  wire logic                   hit,
   input  wire logic [2:0]             cur_mode,
   input  wire logic [TIMER_WIDTH-1:0] cur_delay_count,
   input  wire logic [TIMER_WIDTH-1:0] cur_holdoff_count,
   input  wire logic                   cur_pending,
   input  wire logic [TIMER_WIDTH-1:0] delay_ticks,
   input  wire logic [TIMER_WIDTH-1:0] holdoff_ticks,
   input  wire logic                   continuous_mode,
   output logic      [2:0]             nxt_mode,
   output logic      [TIMER_WIDTH-1:0] nxt_delay_count,
   output logic      [TIMER_WIDTH-1:0] nxt_holdoff_count,
   output logic                        nxt_pending,
   output tdh_pkg::result_type         result
);

   logic [TIMER_WIDTH-1:0] delay_inc;
   logic [TIMER_WIDTH-1:0] holdoff_inc;

   assign delay_inc   = cur_delay_count + TIMER_WIDTH'(1);
   assign holdoff_inc = cur_holdoff_count + TIMER_WIDTH'(1);

   always_comb begin
      logic [2:0] mode;
      mode              = cur_mode;
      nxt_mode          = cur_mode;
      nxt_delay_count   = cur_delay_count;
      nxt_holdoff_count = cur_holdoff_count;
      nxt_pending       = cur_pending;
      result            = '0;

      unique case (req_code)
         tdh_pkg::REQ_INITIATE: begin
            nxt_mode = tdh_pkg::ST_INIT;
         end
         tdh_pkg::REQ_ABORT: begin
            nxt_mode = tdh_pkg::ST_IDLE;
         end
         tdh_pkg::REQ_IMMEDIATE: begin
            nxt_pending = 1'b1;
         end
         default: begin
            // A tick consumes any pending immediate request.
            result.fired = cur_pending;
            nxt_pending  = 1'b0;

            // An initiated sequencer restarts the trigger logic and arms in
            // the same tick, then evaluates the hit as armed.
            if (cur_mode == tdh_pkg::ST_INIT) begin
               result.logic_restart = 1'b1;
               result.armed_event   = 1'b1;
               mode                 = tdh_pkg::ST_ARMED;
            end
            nxt_mode = mode;

            unique case (mode)
               tdh_pkg::ST_ARMED: begin
                  if (hit) begin
                     nxt_delay_count = '0;
                     if (delay_ticks != '0) begin
                        nxt_mode             = tdh_pkg::ST_DELAYED;
                        result.delayed_event = 1'b1;
                     end else begin
                        result.fired = 1'b1;
                        if (!continuous_mode) begin
                           nxt_mode = tdh_pkg::ST_IDLE;
                        end else begin
                           nxt_holdoff_count = '0;
                           if (holdoff_ticks != '0) begin
                              nxt_mode             = tdh_pkg::ST_HELDOFF;
                              result.heldoff_event = 1'b1;
                           end else begin
                              nxt_mode = tdh_pkg::ST_INIT;
                           end
                        end
                     end
                  end
               end
               tdh_pkg::ST_DELAYED: begin
                  nxt_delay_count = delay_inc;
                  if (delay_inc >= delay_ticks) begin
                     result.fired = 1'b1;
                     if (!continuous_mode) begin
                        nxt_mode = tdh_pkg::ST_IDLE;
                     end else if (holdoff_ticks != '0) begin
                        // Holdoff continues counting from the elapsed delay.
                        nxt_holdoff_count    = delay_inc;
                        nxt_mode             = tdh_pkg::ST_HELDOFF;
                        result.heldoff_event = 1'b1;
                     end else begin
                        nxt_mode = tdh_pkg::ST_INIT;
                     end
                  end
               end
               tdh_pkg::ST_HELDOFF: begin
                  nxt_holdoff_count = holdoff_inc;
                  if (holdoff_inc >= holdoff_ticks) begin
                     nxt_mode = tdh_pkg::ST_INIT;
                  end
               end
               default: begin
                  // Idle and unused codes hold.
               end
            endcase
         end
      endcase

      result.fsm_state = nxt_mode;
   end

endmodule

`default_nettype wire

// File: sv/trigger_delay_holdoff_fsm_core.sv
// ----------------------------------------------------------------------------
// trigger_delay_holdoff_fsm_core
// Trigger sequencer with idle, initiated, armed, delayed and holdoff states.
// ----------------------------------------------------------------------------
// Path: an accepted request beat passes the input register, then the
// response register, from which its response beat is offered.
// Throughput: one request per clock unless the response side stalls; the
// state update is a single pass of counter increments and compares between the two registers.
// Reset (synchronous, active high) returns the sequencer to idle, clears both
// counters, the pending immediate request and all configuration registers.
`default_nettype none

module trigger_delay_holdoff_fsm_core #(
   parameter int TIMER_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,

   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [1:0]                     req_type,
   input  wire logic                           req_logic_hit,

   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_fired,
   output logic      [2:0]                     rsp_fsm_state,
   output logic                                rsp_logic_restart,
   output logic                                rsp_armed_event,
   output logic                                rsp_delayed_event,
   output logic                                rsp_heldoff_event,

   input  wire logic                           csr_write_en,
   input  wire logic [1:0]                     csr_index,
   input  wire logic [tdh_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers. The timer registers keep their low
   // TIMER_WIDTH bits.
   logic [TIMER_WIDTH-1:0] delay_ticks_ff;
   logic [TIMER_WIDTH-1:0] holdoff_ticks_ff;
   logic                   continuous_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ticks_ff     <= '0;
         holdoff_ticks_ff   <= '0;
         continuous_mode_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            tdh_pkg::CSR_DELAY_TICKS:     delay_ticks_ff     <= csr_wdata[TIMER_WIDTH-1:0];
            tdh_pkg::CSR_HOLDOFF_TICKS:   holdoff_ticks_ff   <= csr_wdata[TIMER_WIDTH-1:0];
            tdh_pkg::CSR_CONTINUOUS_MODE: continuous_mode_ff <= csr_wdata[0];
            default: begin
               // Index outside the register list: ignored.
            end
         endcase
      end
   end

   // Input register. It moves into the update stage whenever the response
   // register is empty or being drained in the same cycle, so a new beat is
   // taken every clock unless the response side stalls.
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [1:0] in_type_ff;
   logic       in_hit_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       advance;
   logic       req_accept;

   assign advance    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_type_ff <= req_type;
         in_hit_ff  <= req_logic_hit;
      end
   end

   // Sequencer state. It is updated exactly once for each beat, at the edge
   // where that beat moves into the response register.
   logic [2:0]             mode_ff;
   logic [TIMER_WIDTH-1:0] delay_count_ff;
   logic [TIMER_WIDTH-1:0] holdoff_count_ff;
   logic                   pending_ff;
   logic [2:0]             mode_in;
   logic [TIMER_WIDTH-1:0] delay_count_in;
   logic [TIMER_WIDTH-1:0] holdoff_count_in;
   logic                   pending_in;
   tdh_pkg::result_type    result_in;
   tdh_pkg::result_type    result_ff;

   tdh_step #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_step (
      .req_code          (in_type_ff),
      .hit               (in_hit_ff),
      .cur_mode          (mode_ff),
      .cur_delay_count   (delay_count_ff),
      .cur_holdoff_count (holdoff_count_ff),
      .cur_pending       (pending_ff),
      .delay_ticks       (delay_ticks_ff),
      .holdoff_ticks     (holdoff_ticks_ff),
      .continuous_mode   (continuous_mode_ff),
      .nxt_mode          (mode_in),
      .nxt_delay_count   (delay_count_in),
      .nxt_holdoff_count (holdoff_count_in),
      .nxt_pending       (pending_in),
      .result            (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= tdh_pkg::ST_IDLE;
         delay_count_ff   <= '0;
         holdoff_count_ff <= '0;
         pending_ff       <= 1'b0;
      end else if (advance) begin
         mode_ff          <= mode_in;
         delay_count_ff   <= delay_count_in;
         holdoff_count_ff <= holdoff_count_in;
         pending_ff       <= pending_in;
      end
   end

   // Response register: holds its beat while the consumer stalls.
   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fired         = result_ff.fired;
   assign rsp_fsm_state     = result_ff.fsm_state;
   assign rsp_logic_restart = result_ff.logic_restart;
   assign rsp_armed_event   = result_ff.armed_event;
   assign rsp_delayed_event = result_ff.delayed_event;
   assign rsp_heldoff_event = result_ff.heldoff_event;

   // Assertions.

   // The state register never leaves the five defined codes.
   assert property (@(posedge clock) disable iff (reset)
      mode_ff == tdh_pkg::ST_IDLE || mode_ff == tdh_pkg::ST_INIT ||
      mode_ff == tdh_pkg::ST_ARMED || mode_ff == tdh_pkg::ST_DELAYED ||
      mode_ff == tdh_pkg::ST_HELDOFF)
      else $error("sequencer state left the defined codes");

   // A command beat never fires and never pulses an event.
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_type_ff != tdh_pkg::REQ_TICK) |=>
         (rsp_valid_ff && !result_ff.fired && !result_ff.logic_restart &&
          !result_ff.armed_event && !result_ff.delayed_event &&
          !result_ff.heldoff_event))
      else $error("command beat produced a fire or event pulse");

   // Arming always comes with a restart of the trigger logic.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.armed_event) |-> result_ff.logic_restart)
      else $error("armed without logic restart");

   // A delayed event always comes with the delayed state, never with a holdoff event.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.delayed_event) |->
         (!result_ff.heldoff_event && result_ff.fsm_state == tdh_pkg::ST_DELAYED))
      else $error("delayed event with inconsistent state");

endmodule

`default_nettype wire

// File: verif/trigger_seq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trigger_seq_checker
// Watches the request, response and register ports of the trigger sequencer.
// It keeps its own copy of the sequencer state, predicts one response beat per
// accepted request beat, and compares each response beat field by field.
// ----------------------------------------------------------------------------

module trigger_seq_checker #(
   parameter int TIMER_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [1:0]                     req_type,
   input  logic                           req_logic_hit,

   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic                           rsp_fired,
   input  logic [2:0]                     rsp_fsm_state,
   input  logic                           rsp_logic_restart,
   input  logic                           rsp_armed_event,
   input  logic                           rsp_delayed_event,
   input  logic                           rsp_heldoff_event,

   input  logic                           csr_write_en,
   input  logic [1:0]                     csr_index,
   input  logic [tdh_pkg::CSR_DATA_W-1:0] csr_wdata,

   output int                             fail_count,
   output int                             pending,
   output int                             beats_checked,
   output int                             fire_count,
   output logic [7:0]                     states_seen
);

   // Register copy.
   logic [TIMER_WIDTH-1:0] delay_ticks;
   logic [TIMER_WIDTH-1:0] holdoff_ticks;
   logic                   cont_mode;

   // Sequencer state copy.
   logic [2:0]             seq_state;
   logic [TIMER_WIDTH-1:0] delay_count;
   logic [TIMER_WIDTH-1:0] holdoff_count;
   logic                   imm_pending;

   tdh_pkg::result_type    expected_beats[$];
   tdh_pkg::result_type    exp_beat;

   // Advances the state copy by one request beat and returns the response.
   function automatic tdh_pkg::result_type predict_trigger_beat(input logic [1:0] kind,
                                                                input logic       hit);
      tdh_pkg::result_type beat;
      beat = '0;
      case (kind)
         tdh_pkg::REQ_INITIATE:  seq_state = tdh_pkg::ST_INIT;
         tdh_pkg::REQ_ABORT:     seq_state = tdh_pkg::ST_IDLE;
         tdh_pkg::REQ_IMMEDIATE: imm_pending = 1'b1;
         default: begin
            // A pending immediate request fires on any tick, whatever the state.
            beat.fired  = imm_pending;
            imm_pending = 1'b0;
            if (seq_state == tdh_pkg::ST_INIT) begin
               beat.logic_restart = 1'b1;
               beat.armed_event   = 1'b1;
               seq_state          = tdh_pkg::ST_ARMED;
            end
            if (seq_state == tdh_pkg::ST_ARMED) begin
               if (hit) begin
                  delay_count = '0;
                  if (delay_ticks != '0) begin
                     seq_state          = tdh_pkg::ST_DELAYED;
                     beat.delayed_event = 1'b1;
                  end else begin
                     beat.fired = 1'b1;
                     if (!cont_mode) begin
                        seq_state = tdh_pkg::ST_IDLE;
                     end else begin
                        holdoff_count = '0;
                        if (holdoff_ticks != '0) begin
                           seq_state          = tdh_pkg::ST_HELDOFF;
                           beat.heldoff_event = 1'b1;
                        end else begin
                           seq_state = tdh_pkg::ST_INIT;
                        end
                     end
                  end
               end
            end else if (seq_state == tdh_pkg::ST_DELAYED) begin
               delay_count = delay_count + TIMER_WIDTH'(1);
               if (delay_count >= delay_ticks) begin
                  beat.fired = 1'b1;
                  if (!cont_mode) begin
                     seq_state = tdh_pkg::ST_IDLE;
                  end else if (holdoff_ticks != '0) begin
                     // Holdoff counts on from the delay already spent.
                     holdoff_count      = delay_count;
                     seq_state          = tdh_pkg::ST_HELDOFF;
                     beat.heldoff_event = 1'b1;
                  end else begin
                     seq_state = tdh_pkg::ST_INIT;
                  end
               end
            end else if (seq_state == tdh_pkg::ST_HELDOFF) begin
               holdoff_count = holdoff_count + TIMER_WIDTH'(1);
               if (holdoff_count >= holdoff_ticks) begin
                  seq_state = tdh_pkg::ST_INIT;
               end
            end
         end
      endcase
      beat.fsm_state = seq_state;
      return beat;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         delay_ticks   = '0;
         holdoff_ticks = '0;
         cont_mode     = 1'b0;
         seq_state     = tdh_pkg::ST_IDLE;
         delay_count   = '0;
         holdoff_count = '0;
         imm_pending   = 1'b0;
         fail_count    = 0;
         beats_checked = 0;
         fire_count    = 0;
         states_seen   = '0;
         expected_beats.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               tdh_pkg::CSR_DELAY_TICKS:     delay_ticks   = csr_wdata[TIMER_WIDTH-1:0];
               tdh_pkg::CSR_HOLDOFF_TICKS:   holdoff_ticks = csr_wdata[TIMER_WIDTH-1:0];
               tdh_pkg::CSR_CONTINUOUS_MODE: cont_mode     = csr_wdata[0];
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               $error("response beat arrived with no request outstanding");
               fail_count++;
            end else begin
               exp_beat = expected_beats.pop_front();
               check_field("fired", 32'(exp_beat.fired), 32'(rsp_fired));
               check_field("fsm_state", 32'(exp_beat.fsm_state), 32'(rsp_fsm_state));
               check_field("logic_restart", 32'(exp_beat.logic_restart),
                           32'(rsp_logic_restart));
               check_field("armed_event", 32'(exp_beat.armed_event),
                           32'(rsp_armed_event));
               check_field("delayed_event", 32'(exp_beat.delayed_event),
                           32'(rsp_delayed_event));
               check_field("heldoff_event", 32'(exp_beat.heldoff_event),
                           32'(rsp_heldoff_event));
            end
            beats_checked++;
            if (rsp_fired === 1'b1) fire_count++;
            if (!$isunknown(rsp_fsm_state)) states_seen[rsp_fsm_state] = 1'b1;
         end

         if (req_valid && !req_stall) begin
            expected_beats.push_back(predict_trigger_beat(req_type, req_logic_hit));
         end
      end
      pending = expected_beats.size();
   end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the trigger delay / holdoff sequencer. A directed
// walk through every state and corner comes first, then randomized phases,
// each with its own register setting, with random gaps and stalls on both
// channels. The checker beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int TIMER_WIDTH = 32;

   logic                           clock         = 1'b0;
   logic                           reset         = 1'b1;
   logic                           req_valid     = 1'b0;
   logic                           req_stall;
   logic [1:0]                     req_type      = tdh_pkg::REQ_TICK;
   logic                           req_logic_hit = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall     = 1'b0;
   logic                           rsp_fired;
   logic [2:0]                     rsp_fsm_state;
   logic                           rsp_logic_restart;
   logic                           rsp_armed_event;
   logic                           rsp_delayed_event;
   logic                           rsp_heldoff_event;
   logic                           csr_write_en  = 1'b0;
   logic [1:0]                     csr_index     = tdh_pkg::CSR_DELAY_TICKS;
   logic [tdh_pkg::CSR_DATA_W-1:0] csr_wdata     = '0;

   int         fail_count;
   int         pending;
   int         beats_checked;
   int         fire_count;
   logic [7:0] states_seen;

   // Set by the stimulus, read by the receiver process.
   bit no_idle   = 1'b0;   // when set, neither side inserts gaps
   bit long_hold = 1'b0;   // request for one long receiver hold-off
   int beats_sent = 0;
   int settings   = 0;

   always #10 clock = ~clock;

   trigger_delay_holdoff_fsm_core #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_logic_hit     (req_logic_hit),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_fired         (rsp_fired),
      .rsp_fsm_state     (rsp_fsm_state),
      .rsp_logic_restart (rsp_logic_restart),
      .rsp_armed_event   (rsp_armed_event),
      .rsp_delayed_event (rsp_delayed_event),
      .rsp_heldoff_event (rsp_heldoff_event),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   trigger_seq_checker #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_logic_hit     (req_logic_hit),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_fired         (rsp_fired),
      .rsp_fsm_state     (rsp_fsm_state),
      .rsp_logic_restart (rsp_logic_restart),
      .rsp_armed_event   (rsp_armed_event),
      .rsp_delayed_event (rsp_delayed_event),
      .rsp_heldoff_event (rsp_heldoff_event),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending           (pending),
      .beats_checked     (beats_checked),
      .fire_count        (fire_count),
      .states_seen       (states_seen)
   );

   // Idle length in cycles: mostly none, often a short one, now and then a
   // long one, so that gaps land on every step of a delay or holdoff count.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle)    return 0;
      if (roll < 60)  return 0;
      if (roll < 92)  return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Timer setting: zero and one are frequent since they take the special
   // paths (no delay, immediate re-initiate, count already past). Small
   // values keep the fires coming. Huge values park the sequencer until an
   // abort gets it out again.
   function automatic logic [31:0] pick_timer();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return 32'd0;
      if (roll < 45) return 32'd1;
      if (roll < 85) return $urandom_range(2, 6);
      if (roll < 93) return $urandom_range(7, 40);
      if (roll < 96) return 32'hFFFF_FFFF;
      return $urandom | 32'h8000_0000;
   endfunction

   // Offers one request beat after a random gap and holds it until accepted.
   // Inputs change on the falling edge only; acceptance is judged on the
   // rising edge, the same way the block sees it.
   task automatic send_beat(input logic [1:0] kind, input logic hit);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_logic_hit <= hit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   // Drops valid and waits until every response beat is back. Each request
   // beat has exactly one response, so an empty queue means the block is
   // idle; extra waiting after that covers the two-stage pipeline anyway.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      settings++;
   endtask

   // Receiver: random stall runs, with a single long hold-off once the
   // stimulus asks for one. During the long hold the sender keeps offering,
   // so the pipeline fills and the block has to stall its request side.
   initial begin : response_side
      int run;
      bit long_done;
      long_done = 1'b0;
      forever begin
         if (long_hold && !long_done) begin
            long_done = 1'b1;
            run = 80;
         end else begin
            run = pick_gap();
         end
         repeat (run) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   initial begin : stimulus
      int         phase;
      int         n;
      int         n_items;
      int         roll;
      int         hit_pct;
      logic [1:0] kind;

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // ---- Directed part -------------------------------------------------
      // Registers are all zero here: no delay, no holdoff, single shot.
      send_beat(tdh_pkg::REQ_TICK, 1'b1);        // hit while idle is ignored
      send_beat(tdh_pkg::REQ_IMMEDIATE, 1'b0);
      send_beat(tdh_pkg::REQ_TICK, 1'b0);        // immediate fires in idle
      send_beat(tdh_pkg::REQ_INITIATE, 1'b0);
      send_beat(tdh_pkg::REQ_TICK, 1'b0);        // restart and arm, no hit
      send_beat(tdh_pkg::REQ_TICK, 1'b1);        // fires at once, back to idle

      // Short delay, short holdoff, continuous. The continuous bit sits in a
      // word of all ones to show that only bit zero counts.
      settle();
      write_reg(tdh_pkg::CSR_DELAY_TICKS, 32'd2);
      write_reg(tdh_pkg::CSR_HOLDOFF_TICKS, 32'd1);
      write_reg(tdh_pkg::CSR_CONTINUOUS_MODE, 32'hFFFF_FFFF);
      send_beat(tdh_pkg::REQ_INITIATE, 1'b0);
      send_beat(tdh_pkg::REQ_TICK, 1'b1);        // arm and enter delay together
      send_beat(tdh_pkg::REQ_IMMEDIATE, 1'b0);
      send_beat(tdh_pkg::REQ_TICK, 1'b0);        // pending immediate while delayed
      send_beat(tdh_pkg::REQ_TICK, 1'b0);        // delay done, holdoff starts past
      send_beat(tdh_pkg::REQ_TICK, 1'b0);        // holdoff over, re-initiate
      send_beat(tdh_pkg::REQ_TICK, 1'b0);
      send_beat(tdh_pkg::REQ_IMMEDIATE, 1'b0);
      send_beat(tdh_pkg::REQ_ABORT, 1'b0);       // pending request survives abort
      send_beat(tdh_pkg::REQ_TICK, 1'b0);

      // Zero timers in continuous mode: each hit fires and re-initiates.
      settle();
      write_reg(tdh_pkg::CSR_DELAY_TICKS, 32'd0);
      write_reg(tdh_pkg::CSR_HOLDOFF_TICKS, 32'd0);
      send_beat(tdh_pkg::REQ_INITIATE, 1'b0);
      send_beat(tdh_pkg::REQ_TICK, 1'b1);
      send_beat(tdh_pkg::REQ_TICK, 1'b1);

      // Largest timers, then the delay shrunk below the running count.
      settle();
      write_reg(tdh_pkg::CSR_DELAY_TICKS, 32'hFFFF_FFFF);
      write_reg(tdh_pkg::CSR_HOLDOFF_TICKS, 32'hFFFF_FFFF);
      send_beat(tdh_pkg::REQ_TICK, 1'b1);
      send_beat(tdh_pkg::REQ_TICK, 1'b0);
      send_beat(tdh_pkg::REQ_TICK, 1'b0);
      settle();
      write_reg(tdh_pkg::CSR_DELAY_TICKS, 32'd1);
      send_beat(tdh_pkg::REQ_TICK, 1'b0);        // count already past: fires
      send_beat(tdh_pkg::REQ_TICK, 1'b0);        // parked in holdoff
      send_beat(tdh_pkg::REQ_ABORT, 1'b0);

      // ---- Random phases -------------------------------------------------
      // Each phase gets a fresh register setting. Mostly ticks, so that
      // initiate/arm/delay/holdoff sequences run to completion, with the
      // commands sprinkled in to break them up at random points.
      for (phase = 0; phase < 12; phase++) begin
         settle();
         write_reg(tdh_pkg::CSR_DELAY_TICKS, pick_timer());
         write_reg(tdh_pkg::CSR_HOLDOFF_TICKS, pick_timer());
         write_reg(tdh_pkg::CSR_CONTINUOUS_MODE, $urandom);
         no_idle = (phase == 2 || phase == 5);
         if (phase == 2) long_hold = 1'b1;
         n_items = (phase == 2) ? 150 : 63;
         hit_pct = $urandom_range(10, 60);
         for (n = 0; n < n_items; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 74)      kind = tdh_pkg::REQ_TICK;
            else if (roll < 84) kind = tdh_pkg::REQ_INITIATE;
            else if (roll < 92) kind = tdh_pkg::REQ_IMMEDIATE;
            else                kind = tdh_pkg::REQ_ABORT;
            send_beat(kind, $urandom_range(0, 99) < hit_pct);
         end
      end
      no_idle = 1'b0;

      // Drain, then give the pipeline time to show any stray beat.
      settle();
      repeat (8) @(negedge clock);

      $display("Sent %0d request beats over %0d register writes.", beats_sent, settings);
      $display("Checked %0d response beats, %0d fires, states reached %b.",
               beats_checked, fire_count, states_seen[4:0]);
      if (fail_count == 0 && pending == 0) begin
         $display("[trigger_delay_holdoff_fsm_core] OK");
      end else begin
         $display("[trigger_delay_holdoff_fsm_core] ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (about 1.5 ms).
   initial begin : watchdog
      #20_000_000;
      $display("Timed out with %0d response beats outstanding.", pending);
      $display("[trigger_delay_holdoff_fsm_core] ERROR");
      $finish;
   end

endmodule
